// ----- hdl/crcb_pkg.sv -----
package crcb_pkg;

   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned BIT_AW    = 5;
   localparam logic [BIT_AW-1:0] BIT_MAX = 5'd31;

   typedef enum logic [1:0] {
      KIND_MARK  = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPAN,
      ST_WALK,
      ST_CLEAR
   } state_type;

endpackage

// ----- hdl/code_region_coverage_bitmap.sv -----
// Channel   Ports                                   Handshake
// request   req_kind, req_address, req_length       start high while busy low
// response  rsp_covered                             rsp_strobe, one cycle
//
// The map is stored as 32 region bits per word of a one-read, one-write RAM.
// A mark or query goes through the span state and then walks the words of the
// span, one RAM read per cycle; an empty span responds from the span state.
// A query stops at the first marked word. A clear sweeps all words, one per
// cycle, then responds. Reset runs the same sweep with busy high and no
// response. An unknown kind responds without a walk. The receiver cannot stall.
module code_region_coverage_bitmap import crcb_pkg::*; #(
   parameter int unsigned REGION_COUNT = 2048,
   parameter int unsigned REGION_SHIFT = 12,
   parameter logic [31:0] BASE_ADDR    = 32'h8000_0000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_kind,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [ADDR_W-1:0] req_length,
   output logic              rsp_strobe,
   output logic              rsp_covered
);

   localparam int unsigned WORD_COUNT = (REGION_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam logic [ADDR_W-1:0] COUNT_LIMIT = ADDR_W'(REGION_COUNT);
   localparam logic [ADDR_W-1:0] STOP_MAX    = ADDR_W'(REGION_COUNT - 1);
   localparam logic [WORD_AW-1:0] WORD_LAST  = WORD_AW'(WORD_COUNT - 1);

   state_type            state_ff, state_in;
   logic                 is_query_ff, is_query_in;
   logic [ADDR_W-1:0]    off_first_ff, off_first_in;
   logic [ADDR_W-1:0]    off_last_ff, off_last_in;
   logic [WORD_AW-1:0]   first_word_ff, first_word_in;
   logic [WORD_AW-1:0]   last_word_ff, last_word_in;
   logic [BIT_AW-1:0]    first_bit_ff, first_bit_in;
   logic [BIT_AW-1:0]    last_bit_ff, last_bit_in;
   logic [WORD_AW:0]     ptr_ff, ptr_in;
   logic [WORD_AW-1:0]   pend_word_ff, pend_word_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_covered_ff, rsp_covered_in;
   logic                 clr_rsp_ff, clr_rsp_in;

   logic [ADDR_W-1:0]    first_region;
   logic [ADDR_W-1:0]    last_region;
   logic [ADDR_W-1:0]    stop_region;
   logic                 span_empty;
   logic [WORD_BITS-1:0] mask;
   logic                 hit;
   logic                 more;

   logic                 wr_en;
   logic [WORD_AW-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [WORD_AW-1:0]   rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   crcb_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   crcb_mask #(
      .WORD_AW (WORD_AW)
   ) u_mask (
      .word       (pend_word_ff),
      .first_word (first_word_ff),
      .last_word  (last_word_ff),
      .first_bit  (first_bit_ff),
      .last_bit   (last_bit_ff),
      .mask       (mask)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_query_ff    <= is_query_in;
      off_first_ff   <= off_first_in;
      off_last_ff    <= off_last_in;
      first_word_ff  <= first_word_in;
      last_word_ff   <= last_word_in;
      first_bit_ff   <= first_bit_in;
      last_bit_ff    <= last_bit_in;
      pend_word_ff   <= pend_word_in;
      rsp_covered_ff <= rsp_covered_in;
   end

   // Region indexes of the span ends; the end is clamped to the last entry.
   always_comb begin
      first_region = off_first_ff >> REGION_SHIFT;
      last_region  = off_last_ff >> REGION_SHIFT;
      span_empty   = (first_region > last_region) || (first_region >= COUNT_LIMIT);
      stop_region  = (last_region > STOP_MAX) ? STOP_MAX : last_region;
   end

   assign hit  = |(rd_data & mask);
   assign more = (ptr_ff <= {1'b0, last_word_ff}) && !(is_query_ff && hit);

   always_comb begin
      state_in       = state_ff;
      is_query_in    = is_query_ff;
      off_first_in   = off_first_ff;
      off_last_in    = off_last_ff;
      first_word_in  = first_word_ff;
      last_word_in   = last_word_ff;
      first_bit_in   = first_bit_ff;
      last_bit_in    = last_bit_ff;
      ptr_in         = ptr_ff;
      pend_word_in   = pend_word_ff;
      clr_rsp_in     = clr_rsp_ff;
      rsp_valid_in   = 1'b0;
      rsp_covered_in = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = pend_word_ff;
      wr_data        = rd_data | mask;
      rd_en          = 1'b0;
      rd_addr        = ptr_ff[WORD_AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // The end offset is address + length - 1 - base, and -1 - base is ~base.
               off_first_in = req_address - BASE_ADDR;
               off_last_in  = req_address + req_length + ~BASE_ADDR;
               is_query_in  = (kind_type'(req_kind) == KIND_QUERY);
               case (kind_type'(req_kind)) inside
                  KIND_MARK, KIND_QUERY: begin
                     state_in = ST_SPAN;
                  end
                  KIND_CLEAR: begin
                     state_in   = ST_CLEAR;
                     ptr_in     = '0;
                     clr_rsp_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SPAN: begin
            first_word_in = first_region[BIT_AW +: WORD_AW];
            first_bit_in  = first_region[BIT_AW-1:0];
            last_word_in  = stop_region[BIT_AW +: WORD_AW];
            last_bit_in   = stop_region[BIT_AW-1:0];
            if (span_empty) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = first_region[BIT_AW +: WORD_AW];
               pend_word_in = first_region[BIT_AW +: WORD_AW];
               ptr_in       = {1'b0, first_region[BIT_AW +: WORD_AW]} + (WORD_AW+1)'(1);
               state_in     = ST_WALK;
            end
         end
         ST_WALK: begin
            // The word read last cycle is processed while the next one is read.
            wr_en = !is_query_ff;
            if (more) begin
               rd_en        = 1'b1;
               pend_word_in = ptr_ff[WORD_AW-1:0];
               ptr_in       = ptr_ff + (WORD_AW+1)'(1);
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_covered_in = is_query_ff && hit;
               state_in       = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[WORD_AW-1:0];
            wr_data = '0;
            ptr_in  = ptr_ff + (WORD_AW+1)'(1);
            if (ptr_ff[WORD_AW-1:0] == WORD_LAST) begin
               rsp_valid_in = clr_rsp_ff;
               clr_rsp_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_covered = rsp_covered_ff;

`ifndef NO_ASSERTIONS
   // A set covered bit can only come from a query walk.
   a_covered_from_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_covered) |-> ($past(state_ff) == ST_WALK && is_query_ff))
      else $error("covered reported outside a query walk");

   // A query never modifies the map.
   a_no_write_on_query: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || (state_ff == ST_WALK && !is_query_ff)))
      else $error("map written during a query");

   // The read pointer runs exactly one word ahead of the word being processed.
   a_ptr_ahead: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (ptr_ff == ({1'b0, pend_word_ff} + (WORD_AW+1)'(1))))
      else $error("walk pointer out of step");

   // The processed word stays inside the span.
   a_word_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |->
         (pend_word_ff >= first_word_ff && pend_word_ff <= last_word_ff))
      else $error("walk left the span");

   // The clearing sweep writes only zero words.
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (wr_en && wr_data == '0))
      else $error("clear sweep wrote a nonzero word");
`endif

endmodule

// ----- hdl/crcb_ram.sv -----
module crcb_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/crcb_mask.sv -----
module crcb_mask import crcb_pkg::*; #(
   parameter int unsigned WORD_AW = 6
) (
   input  logic [WORD_AW-1:0]   word,
   input  logic [WORD_AW-1:0]   first_word,
   input  logic [WORD_AW-1:0]   last_word,
   input  logic [BIT_AW-1:0]    first_bit,
   input  logic [BIT_AW-1:0]    last_bit,
   output logic [WORD_BITS-1:0] mask
);

   logic [BIT_AW-1:0] lo;
   logic [BIT_AW-1:0] hi;

   // Only the end words of a span are partial; inner words are fully covered.
   always_comb begin
      lo   = (word == first_word) ? first_bit : '0;
      hi   = (word == last_word) ? last_bit : BIT_MAX;
      mask = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (BIT_MAX - hi));
   end

endmodule
